// ===== hw/rtl/srtf_pkg.sv =====
// Shared constants and types for the SRTF scheduler.
`timescale 1ns / 1ps
`default_nettype none

package srtf_pkg;

    localparam int MAX_SLOTS = 8;
    localparam int SLOT_BITS = $clog2(MAX_SLOTS);
    localparam int CNT_BITS  = $clog2(MAX_SLOTS + 1);
    localparam int TIME_BITS = 16;
    localparam int CFG_BITS  = 4;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [CFG_BITS-1:0] ACTIVE_RESET = CFG_BITS'(5);

    typedef struct packed {
        logic [TIME_BITS-1:0] arrival;
        logic [TIME_BITS-1:0] remaining;
        logic [TIME_BITS-1:0] burst;
    } t_entry;

endpackage

`default_nettype wire

// ===== hw/rtl/srtf_scheduler.sv =====
// Top level of the shortest-remaining-time-first scheduler.
//
// Usage: drive a transaction on i_kind/i_slot/i_arrival/i_burst with i_start;
// it is taken at a rising edge where i_start is high and o_busy is low.
// A load transaction writes one job slot in the same edge and gives no result;
// o_busy stays low, so another transaction may follow in the next cycle.
// A tick transaction scans the active slots held in the slot memory, one read
// per cycle through its registered read port, then writes the picked slot back.
// Its result appears on the o_ result ports, held until the next tick completes,
// with o_valid high for one cycle after the scan, drain and exec states;
// o_busy falls in the cycle o_valid rises.
// No new transaction is taken until the tick is through: o_busy stays high
// while the scan walks the single read port of the slot memory.
// The receiver cannot stall: each result is valid for exactly one cycle.
// The active slot count is written through i_cfg_we/i_cfg_data; the user must write it only while idle (not enforced).
// Reset clears the time counter, marks every slot done (no job loaded) and
// sets the active count to 5; slot memory contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module srtf_scheduler (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    output logic                                 o_busy,
    input  wire logic                            i_kind,
    input  wire logic [srtf_pkg::SLOT_BITS-1:0]  i_slot,
    input  wire logic [srtf_pkg::TIME_BITS-1:0]  i_arrival,
    input  wire logic [srtf_pkg::TIME_BITS-1:0]  i_burst,
    input  wire logic                            i_cfg_we,
    input  wire logic [srtf_pkg::CFG_BITS-1:0]   i_cfg_data,
    output logic                                 o_valid,
    output logic                                 o_ran_valid,
    output logic [srtf_pkg::SLOT_BITS-1:0]       o_ran_slot,
    output logic                                 o_finished,
    output logic [srtf_pkg::TIME_BITS-1:0]       o_finish_time,
    output logic [srtf_pkg::TIME_BITS-1:0]       o_turnaround,
    output logic [srtf_pkg::TIME_BITS-1:0]       o_waiting,
    output logic                                 o_all_done
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EXEC  = 2'd3;

    srtf_pkg::t_entry r_mem [srtf_pkg::MAX_SLOTS];
    srtf_pkg::t_entry r_rd_data;
    srtf_pkg::t_entry r_best;
    srtf_pkg::t_entry wr_data;

    logic [1:0]                          r_state;
    logic [srtf_pkg::CFG_BITS-1:0]       r_active;
    logic [srtf_pkg::TIME_BITS-1:0]      r_now;
    logic [srtf_pkg::MAX_SLOTS-1:0]      r_done;
    logic [srtf_pkg::SLOT_BITS-1:0]      r_idx;
    logic [srtf_pkg::SLOT_BITS-1:0]      r_pidx;
    logic                                r_pend;
    logic                                r_found;
    logic [srtf_pkg::SLOT_BITS-1:0]      r_pick;

    logic [srtf_pkg::CNT_BITS-1:0]       n_count;
    logic [srtf_pkg::MAX_SLOTS-1:0]      active_mask;
    logic [srtf_pkg::MAX_SLOTS-1:0]      n_done;
    logic                                load_go;
    logic                                tick_go;
    logic                                rd_en;
    logic                                last_idx;
    logic                                better;
    logic                                wr_en;
    logic [srtf_pkg::SLOT_BITS-1:0]      wr_addr;
    logic [srtf_pkg::TIME_BITS-1:0]      rem_new;
    logic                                fin_now;
    logic [srtf_pkg::TIME_BITS-1:0]      fin_time;
    logic [srtf_pkg::TIME_BITS-1:0]      tat;
    logic [srtf_pkg::TIME_BITS-1:0]      wt;

    assign o_busy  = (r_state != ST_IDLE);
    assign load_go = i_start && !o_busy && (i_kind == srtf_pkg::KIND_LOAD);
    assign tick_go = i_start && !o_busy && (i_kind == srtf_pkg::KIND_TICK);

    // saturate the active count at the table size
    assign n_count = (int'(r_active) > srtf_pkg::MAX_SLOTS)
                   ? srtf_pkg::CNT_BITS'(srtf_pkg::MAX_SLOTS)
                   : srtf_pkg::CNT_BITS'(r_active);

    always_comb begin
        for (int i = 0; i < srtf_pkg::MAX_SLOTS; i++) begin
            active_mask[i] = (i < int'(n_count));
        end
    end

    assign rd_en    = (r_state == ST_SCAN);
    assign last_idx = ((srtf_pkg::CNT_BITS'(r_idx) + srtf_pkg::CNT_BITS'(1)) == n_count);

    // compare the entry coming out of the memory against the best so far
    assign better = r_pend && !r_done[r_pidx] && (r_rd_data.arrival <= r_now)
                  && (!r_found || (r_rd_data.remaining < r_best.remaining));

    assign rem_new  = r_best.remaining - srtf_pkg::TIME_BITS'(1);
    assign fin_now  = r_found && (rem_new == '0);
    assign fin_time = (r_now < srtf_pkg::TIME_MAX) ? r_now + srtf_pkg::TIME_BITS'(1)
                                                   : srtf_pkg::TIME_MAX;
    assign tat      = (fin_time >= r_best.arrival) ? fin_time - r_best.arrival : '0;
    assign wt       = (tat >= r_best.burst) ? tat - r_best.burst : '0;

    always_comb begin
        n_done = r_done;
        if (r_state == ST_EXEC && fin_now) begin
            n_done[r_pick] = 1'b1;
        end
    end

    // one write port: loads from idle, write-back of the picked slot on exec
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = i_slot;
        wr_data = '{arrival: i_arrival, remaining: i_burst, burst: i_burst};
        if (load_go && (int'(i_slot) < srtf_pkg::MAX_SLOTS)) begin
            wr_en = 1'b1;
        end else if (r_state == ST_EXEC && r_found) begin
            wr_en   = 1'b1;
            wr_addr = r_pick;
            wr_data = '{arrival: r_best.arrival, remaining: rem_new, burst: r_best.burst};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= srtf_pkg::ACTIVE_RESET;
            r_now    <= '0;
            r_done   <= '1;
            r_pend   <= 1'b0;
            r_found  <= 1'b0;
            r_idx    <= '0;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            r_pend <= rd_en;
            r_pidx <= r_idx;
            if (better) begin
                r_found <= 1'b1;
                r_best  <= r_rd_data;
                r_pick  <= r_pidx;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (load_go && (int'(i_slot) < srtf_pkg::MAX_SLOTS)) begin
                        r_done[i_slot] <= (i_burst == '0);
                    end
                    if (tick_go) begin
                        r_found <= 1'b0;
                        r_idx   <= '0;
                        r_state <= (n_count == '0) ? ST_DRAIN : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (last_idx) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_idx <= r_idx + srtf_pkg::SLOT_BITS'(1);
                    end
                end
                ST_DRAIN: begin
                    // last read compares this cycle
                    r_state <= ST_EXEC;
                end
                ST_EXEC: begin
                    r_done  <= n_done;
                    if (r_now < srtf_pkg::TIME_MAX) begin
                        r_now <= r_now + srtf_pkg::TIME_BITS'(1);
                    end
                    o_valid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // result payload, held until the next tick completes
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXEC) begin
            o_ran_valid   <= r_found;
            o_ran_slot    <= r_found ? r_pick : '0;
            o_finished    <= fin_now;
            o_finish_time <= fin_now ? fin_time : '0;
            o_turnaround  <= fin_now ? tat : '0;
            o_waiting     <= fin_now ? wt : '0;
            o_all_done    <= &(~active_mask | n_done);
        end
    end

endmodule

`default_nettype wire

// ===== verif/srtf_scheduler_test.sv =====
// Self-checking testbench for the SRTF scheduler with a built-in schedule predictor.
`timescale 1ns / 1ps

module srtf_scheduler_test;

    typedef struct packed {
        logic                           ran_valid;
        logic [srtf_pkg::SLOT_BITS-1:0] ran_slot;
        logic                           finished;
        logic [srtf_pkg::TIME_BITS-1:0] finish_time;
        logic [srtf_pkg::TIME_BITS-1:0] turnaround;
        logic [srtf_pkg::TIME_BITS-1:0] waiting;
        logic                           all_done;
    } t_tick_outcome;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_start;
    logic                           o_busy;
    logic                           i_kind;
    logic [srtf_pkg::SLOT_BITS-1:0] i_slot;
    logic [srtf_pkg::TIME_BITS-1:0] i_arrival;
    logic [srtf_pkg::TIME_BITS-1:0] i_burst;
    logic                           i_cfg_we;
    logic [srtf_pkg::CFG_BITS-1:0]  i_cfg_data;
    logic                           o_valid;
    logic                           o_ran_valid;
    logic [srtf_pkg::SLOT_BITS-1:0] o_ran_slot;
    logic                           o_finished;
    logic [srtf_pkg::TIME_BITS-1:0] o_finish_time;
    logic [srtf_pkg::TIME_BITS-1:0] o_turnaround;
    logic [srtf_pkg::TIME_BITS-1:0] o_waiting;
    logic                           o_all_done;

    // Predicted scheduler state
    srtf_pkg::t_entry               job_table [srtf_pkg::MAX_SLOTS];
    logic                           job_done [srtf_pkg::MAX_SLOTS];
    logic [srtf_pkg::TIME_BITS-1:0] clock_now;
    logic [srtf_pkg::CFG_BITS-1:0]  active_cfg;
    logic                           last_all_done;

    t_tick_outcome        schedule_outcomes [$];
    t_tick_outcome        oldest_outcome;
    int                   mismatch_count = 0;
    int                   items_sent = 0;
    int                   gap_pct = 0;

    srtf_scheduler DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_kind        (i_kind),
        .i_slot        (i_slot),
        .i_arrival     (i_arrival),
        .i_burst       (i_burst),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_ran_valid   (o_ran_valid),
        .o_ran_slot    (o_ran_slot),
        .o_finished    (o_finished),
        .o_finish_time (o_finish_time),
        .o_turnaround  (o_turnaround),
        .o_waiting     (o_waiting),
        .o_all_done    (o_all_done)
    );

    always #4 i_clk = ~i_clk;

    function automatic int active_count();
        return (active_cfg > srtf_pkg::MAX_SLOTS) ? srtf_pkg::MAX_SLOTS : int'(active_cfg);
    endfunction

    function automatic void load_job_slot(input logic [srtf_pkg::SLOT_BITS-1:0] slot,
                                          input logic [srtf_pkg::TIME_BITS-1:0] arrival,
                                          input logic [srtf_pkg::TIME_BITS-1:0] burst);
        job_table[slot].arrival   = arrival;
        job_table[slot].remaining = burst;
        job_table[slot].burst     = burst;
        job_done[slot]            = (burst == '0);
    endfunction

    function automatic t_tick_outcome run_srtf_tick();
        t_tick_outcome                  r;
        int                             n;
        int                             i;
        int                             pick;
        logic                           found;
        logic [srtf_pkg::TIME_BITS-1:0] best;
        logic [srtf_pkg::TIME_BITS-1:0] fin;
        logic [srtf_pkg::TIME_BITS-1:0] tat;
        r     = '0;
        found = 1'b0;
        pick  = 0;
        best  = '0;
        n     = active_count();
        for (i = 0; i < n; i++) begin
            if (!job_done[i] && job_table[i].arrival <= clock_now &&
                (!found || job_table[i].remaining < best)) begin
                found = 1'b1;
                pick  = i;
                best  = job_table[i].remaining;
            end
        end
        if (found) begin
            r.ran_valid = 1'b1;
            r.ran_slot  = srtf_pkg::SLOT_BITS'(pick);
            if (job_table[pick].remaining != '0)
                job_table[pick].remaining = job_table[pick].remaining - 1'b1;
            if (job_table[pick].remaining == '0) begin
                // completion is stamped at the end of the tick, saturating
                fin = (clock_now != srtf_pkg::TIME_MAX) ? clock_now + 1'b1 : srtf_pkg::TIME_MAX;
                tat = (fin >= job_table[pick].arrival) ? fin - job_table[pick].arrival : '0;
                r.finished    = 1'b1;
                r.finish_time = fin;
                r.turnaround  = tat;
                r.waiting     = (tat >= job_table[pick].burst) ?
                                tat - job_table[pick].burst : '0;
                job_done[pick] = 1'b1;
            end
        end
        if (clock_now != srtf_pkg::TIME_MAX)
            clock_now = clock_now + 1'b1;
        r.all_done = 1'b1;
        for (i = 0; i < n; i++) begin
            if (!job_done[i])
                r.all_done = 1'b0;
        end
        last_all_done = r.all_done;
        return r;
    endfunction

    function automatic logic [srtf_pkg::TIME_BITS-1:0] near_arrival();
        int unsigned ahead;
        ahead = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            return srtf_pkg::TIME_BITS'($urandom_range(0, clock_now));
        return (srtf_pkg::TIME_MAX - clock_now < ahead) ? srtf_pkg::TIME_MAX
                                                         : srtf_pkg::TIME_BITS'(clock_now + ahead);
    endfunction

    function automatic logic [srtf_pkg::TIME_BITS-1:0] short_burst();
        if ($urandom_range(0, 15) == 0)
            return '0;
        return srtf_pkg::TIME_BITS'($urandom_range(1, 10));
    endfunction

    function automatic void check_field(input string name,
                                        input logic [srtf_pkg::TIME_BITS-1:0] want,
                                        input logic [srtf_pkg::TIME_BITS-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 100)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // Compare each tick result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (schedule_outcomes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 100)
                    $display("%0t: tick result expected none actual slot %0d finished %0b",
                             $time, o_ran_slot, o_finished);
            end else begin
                oldest_outcome = schedule_outcomes.pop_front();
                check_field("ran_valid", oldest_outcome.ran_valid, o_ran_valid);
                check_field("ran_slot", oldest_outcome.ran_slot, o_ran_slot);
                check_field("finished", oldest_outcome.finished, o_finished);
                check_field("finish_time", oldest_outcome.finish_time, o_finish_time);
                check_field("turnaround", oldest_outcome.turnaround, o_turnaround);
                check_field("waiting", oldest_outcome.waiting, o_waiting);
                check_field("all_done", oldest_outcome.all_done, o_all_done);
            end
        end
    end

    // Drive one transaction, hold it until taken, then update the prediction
    task automatic send_item(input logic kind, input logic [srtf_pkg::SLOT_BITS-1:0] slot,
                             input logic [srtf_pkg::TIME_BITS-1:0] arrival,
                             input logic [srtf_pkg::TIME_BITS-1:0] burst);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_kind    <= kind;
        i_slot    <= slot;
        i_arrival <= arrival;
        i_burst   <= burst;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
        if (kind == srtf_pkg::KIND_LOAD)
            load_job_slot(slot, arrival, burst);
        else
            schedule_outcomes.push_back(run_srtf_tick());
        items_sent++;
    endtask

    task automatic send_load(input logic [srtf_pkg::SLOT_BITS-1:0] slot,
                             input logic [srtf_pkg::TIME_BITS-1:0] arrival,
                             input logic [srtf_pkg::TIME_BITS-1:0] burst);
        send_item(srtf_pkg::KIND_LOAD, slot, arrival, burst);
    endtask

    task automatic send_tick();
        send_item(srtf_pkg::KIND_TICK, '0, '0, '0);
    endtask

    // Drop start and wait until every predicted result has come back
    task automatic drain_schedule();
        int waited;
        waited = 0;
        i_start <= 1'b0;
        while ((schedule_outcomes.size() != 0 || o_busy !== 1'b0) && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        if (schedule_outcomes.size() != 0) begin
            mismatch_count += schedule_outcomes.size();
            $display("%0t: %0d tick results expected actual none", $time,
                     schedule_outcomes.size());
            schedule_outcomes.delete();
        end
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_active(input logic [srtf_pkg::CFG_BITS-1:0] value);
        drain_schedule();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        active_cfg = value;
    endtask

    task automatic test_idle_after_reset();
        send_tick();
    endtask

    task automatic test_preemption_and_ties();
        send_load(3'd0, '0, 16'd2);
        send_load(3'd2, '0, 16'd2);
        // shorter job arrives one tick later; it ties with slot 0, which wins as the lower slot
        send_load(3'd1, clock_now + 1'b1, 16'd1);
        repeat (5) send_tick();
    endtask

    task automatic test_zero_burst();
        send_load(3'd3, '0, '0);
        send_tick();
    endtask

    task automatic test_active_extremes();
        write_active(4'd0);
        send_load(3'd0, '0, 16'd1);
        send_tick();
        write_active(4'd15);
        send_load(3'd7, '0, 16'd1);
        send_load(3'd6, srtf_pkg::TIME_MAX, srtf_pkg::TIME_MAX);
        send_tick();
        send_tick();
        write_active(4'd1);
        send_tick();
        write_active(4'd8);
        send_tick();
    endtask

    task automatic run_job_batch();
        int cnt;
        int t;
        cnt = (active_count() == 0) ? 1 : active_count();
        repeat ($urandom_range(1, cnt + 1))
            send_load(srtf_pkg::SLOT_BITS'($urandom_range(0, cnt - 1)), near_arrival(),
                      short_burst());
        for (t = 0; t < 60; t++) begin
            if ($urandom_range(0, 7) == 0)
                send_load(srtf_pkg::SLOT_BITS'($urandom_range(0, cnt - 1)), near_arrival(),
                          short_burst());
            send_tick();
            if (last_all_done)
                break;
        end
    endtask

    task automatic test_random_rounds();
        int stop_at;
        int pick;
        stop_at = items_sent + 1500;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 3) == 0) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    write_active(4'd0);
                else if (pick == 1)
                    write_active(srtf_pkg::CFG_BITS'($urandom_range(9, 15)));
                else
                    write_active(srtf_pkg::CFG_BITS'($urandom_range(1, 8)));
            end
            gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
            if ($urandom_range(0, 4) != 0) begin
                run_job_batch();
            end else begin
                repeat ($urandom_range(5, 20))
                    send_item(1'($urandom_range(0, 1)),
                              srtf_pkg::SLOT_BITS'($urandom_range(0, 7)),
                              srtf_pkg::TIME_BITS'($urandom), srtf_pkg::TIME_BITS'($urandom));
            end
        end
    endtask

    task automatic test_far_arrivals();
        int t;
        gap_pct = 0;
        // jobs arriving near the top of the time range stay ineligible
        write_active(4'd3);
        send_load(3'd0, srtf_pkg::TIME_MAX - 16'd5, 16'd20);
        send_load(3'd1, 16'd100, 16'd2);
        send_load(3'd2, srtf_pkg::TIME_MAX, 16'd1);
        for (t = 0; t < 40; t++) begin
            send_tick();
            if (last_all_done)
                break;
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_kind     = srtf_pkg::KIND_LOAD;
        i_slot     = '0;
        i_arrival  = '0;
        i_burst    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        for (int i = 0; i < srtf_pkg::MAX_SLOTS; i++) begin
            job_table[i] = '0;
            job_done[i]  = 1'b1;
        end
        clock_now     = '0;
        active_cfg    = srtf_pkg::ACTIVE_RESET;
        last_all_done = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gap_pct = 25;
        test_idle_after_reset();
        test_preemption_and_ties();
        test_zero_burst();
        test_active_extremes();
        test_random_rounds();
        test_far_arrivals();
        drain_schedule();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
